[design/assert_macros.svh]
// Assertion macros used by the checker file of the IMU attitude block.
// Depends on nothing; the using scope provides clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define KIMU_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while in reset.
`define KIMU_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/kimu_pkg.sv]
// Shared constants, register codes and helper functions of the IMU attitude block.
// No dependencies; imported by the top level, kimu_cordic and kimu_div.
package kimu_pkg;

  localparam int unsigned AtanSteps = 23;
  localparam int unsigned DivSteps  = 33;

  // Angles in Q16.16 degrees
  localparam logic signed [31:0] Deg90  = 32'sd5898240;
  localparam logic signed [31:0] Deg180 = 32'sd11796480;

  // Configuration register indexes
  localparam logic [1:0] CFG_ANGLE_NOISE = 2'd0;
  localparam logic [1:0] CFG_BIAS_NOISE  = 2'd1;
  localparam logic [1:0] CFG_MEAS_NOISE  = 2'd2;

  // Register reset values, unsigned Q1.30
  localparam logic [30:0] ANGLE_NOISE_RST = 31'd5368709;
  localparam logic [30:0] BIAS_NOISE_RST  = 31'd3221225;
  localparam logic [30:0] MEAS_NOISE_RST  = 31'd32212254;

  // atan(2^-i) in Q16.16 degrees
  function automatic logic [21:0] atan_tab(input logic [4:0] idx);
    logic [21:0] r;
    case (idx)
      5'd0:    r = 22'd2949120;
      5'd1:    r = 22'd1740967;
      5'd2:    r = 22'd919879;
      5'd3:    r = 22'd466945;
      5'd4:    r = 22'd234379;
      5'd5:    r = 22'd117304;
      5'd6:    r = 22'd58666;
      5'd7:    r = 22'd29335;
      5'd8:    r = 22'd14668;
      5'd9:    r = 22'd7334;
      5'd10:   r = 22'd3667;
      5'd11:   r = 22'd1833;
      5'd12:   r = 22'd917;
      5'd13:   r = 22'd458;
      5'd14:   r = 22'd229;
      5'd15:   r = 22'd115;
      5'd16:   r = 22'd57;
      5'd17:   r = 22'd29;
      5'd18:   r = 22'd14;
      5'd19:   r = 22'd7;
      5'd20:   r = 22'd4;
      5'd21:   r = 22'd2;
      5'd22:   r = 22'd1;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

  // Clamp to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -40'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = $signed(v[31:0]);
    end
    return r;
  endfunction

  // Magnitude of a 32-bit signed value, as a nonnegative 33-bit signed value
  function automatic logic signed [32:0] abs33(input logic signed [31:0] v);
    logic signed [32:0] r;
    if (v < 0) begin
      r = -(33'(v));
    end else begin
      r = 33'(v);
    end
    return r;
  endfunction

endpackage

[design/kalman_imu_roll_pitch_yaw.sv]
// Top level of the IMU attitude block: sequencer, filter state and config regs.
// Depends on kimu_pkg, kimu_mul, kimu_isqrt, kimu_cordic and kimu_div.
//
// channel  direction  handshake                 payload
// in       sink       in_valid_i / in_stall_o   rate_x/y/z, accel_x/y/z, time_step
// out      source     out_valid_o / out_stall_i roll_deg, pitch_deg, yaw_deg
// cfg      sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// Each sample takes a square root, two atan2 runs (normalize steps vary) and four
// gain divisions, with every multiply on one shared 33x33 unit. Axis-aligned or
// zero accel and zero gains skip that work. in_stall_o is high from accept until
// the result enters the output register, which waits while a stalled result is
// held. Reset clears state, loads noise.
module kalman_imu_roll_pitch_yaw import kimu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // sample beat
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] rate_x_i,
  input  logic signed [31:0] rate_y_i,
  input  logic signed [31:0] rate_z_i,
  input  logic signed [31:0] accel_x_i,
  input  logic signed [31:0] accel_y_i,
  input  logic signed [31:0] accel_z_i,
  input  logic        [30:0] time_step_i,
  // result beat
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] roll_deg_o,
  output logic signed [31:0] pitch_deg_o,
  output logic signed [31:0] yaw_deg_o,
  // config writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic        [1:0]  cfg_index_i,
  input  logic        [30:0] cfg_data_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_WB, S_SQRT, S_ATAN, S_RATE, S_T, S_S, S_DIV, S_Y, S_DONE
  } state_e;

  // one entry per use of the shared multiplier
  typedef enum logic [3:0] {
    OP_SQY, OP_SQZ, OP_ANG, OP_DP11, OP_P0, OP_P3,
    OP_KA, OP_KB, OP_C0, OP_C1, OP_C2, OP_C3, OP_YAW
  } op_e;

  state_e st_q;
  op_e    op_q;

  // config registers
  logic [30:0] apn_q, bpn_q, mn_q;

  // latched sample
  logic signed [31:0] gx_q, gy_q, gz_q, ax_q, ay_q, az_q;
  logic        [30:0] dt_q;

  // filter state, index 0 roll, 1 pitch
  logic signed [31:0] ang_q [2];
  logic signed [31:0] bias_q [2];
  logic signed [31:0] p00_q [2];
  logic signed [31:0] p01_q [2];
  logic signed [31:0] p10_q [2];
  logic signed [31:0] p11_q [2];
  logic signed [31:0] meas_q [2];
  logic signed [31:0] yaw_q;

  // scratch
  logic signed [31:0] tmp_q, k0_q, k1_q, a00_q, a01_q;
  logic signed [34:0] dp11_q;
  logic        [63:0] sq_q;
  logic        [31:0] horiz_q, s_q;
  logic               fil_q, go_q, asel_q, dsel_q;

  // output register
  logic               out_valid_q;
  logic signed [31:0] roll_q, pitch_q, yawo_q;

  // shared units
  logic signed [32:0] mul_a, mul_b, dt33, aty, atx;
  logic signed [65:0] prod;
  logic signed [35:0] shr;
  logic signed [31:0] atan_ang, quo, ang_c, bias_c, p00_c, p01_c, p10_c, p11_c, gyro_c;
  logic signed [33:0] s_c;
  logic        [31:0] root;
  logic               sqrt_start, sqrt_done, atan_start, atan_done, div_start, div_done;

  assign ang_c  = ang_q[fil_q];
  assign bias_c = bias_q[fil_q];
  assign p00_c  = p00_q[fil_q];
  assign p01_c  = p01_q[fil_q];
  assign p10_c  = p10_q[fil_q];
  assign p11_c  = p11_q[fil_q];
  assign gyro_c = fil_q ? gy_q : gx_q;
  assign dt33   = $signed({2'b00, dt_q});
  assign shr    = prod[65:30];   // floor shift by 30
  assign s_c    = 34'(p00_c) + $signed({3'b000, mn_q});

  always_comb begin
    case (op_q)
      OP_SQY:  begin mul_a = abs33(ay_q);            mul_b = abs33(ay_q); end
      OP_SQZ:  begin mul_a = abs33(az_q);            mul_b = abs33(az_q); end
      OP_ANG:  begin mul_a = dt33;                   mul_b = 33'(tmp_q);  end
      OP_DP11: begin mul_a = dt33;                   mul_b = 33'(p11_c);  end
      OP_P0:   begin mul_a = dt33;                   mul_b = 33'(tmp_q);  end
      OP_P3:   begin mul_a = $signed({2'b00, bpn_q}); mul_b = dt33;        end
      OP_KA:   begin mul_a = 33'(k0_q);              mul_b = 33'(tmp_q);  end
      OP_KB:   begin mul_a = 33'(k1_q);              mul_b = 33'(tmp_q);  end
      OP_C0:   begin mul_a = 33'(k0_q);              mul_b = 33'(a00_q);  end
      OP_C1:   begin mul_a = 33'(k0_q);              mul_b = 33'(a01_q);  end
      OP_C2:   begin mul_a = 33'(k1_q);              mul_b = 33'(a00_q);  end
      OP_C3:   begin mul_a = 33'(k1_q);              mul_b = 33'(a01_q);  end
      OP_YAW:  begin mul_a = 33'(gz_q);              mul_b = dt33;        end
      default: begin mul_a = '0;                     mul_b = '0;          end
    endcase
  end

  kimu_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign sqrt_start = (st_q == S_SQRT) && go_q;

  kimu_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (sq_q),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  // roll: atan2(ay, az); pitch: atan2(-ax, horiz)
  assign atan_start = (st_q == S_ATAN) && go_q;
  assign aty = asel_q ? -(33'(ax_q)) : 33'(ay_q);
  assign atx = asel_q ? $signed({1'b0, horiz_q}) : 33'(az_q);

  kimu_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (atan_start),
    .y_i     (aty),
    .x_i     (atx),
    .done_o  (atan_done),
    .angle_o (atan_ang)
  );

  assign div_start = (st_q == S_DIV) && go_q;

  kimu_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (dsel_q ? p10_c : p00_c),
    .den_i   (s_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      op_q        <= OP_SQY;
      apn_q       <= ANGLE_NOISE_RST;
      bpn_q       <= BIAS_NOISE_RST;
      mn_q        <= MEAS_NOISE_RST;
      gx_q        <= '0;
      gy_q        <= '0;
      gz_q        <= '0;
      ax_q        <= '0;
      ay_q        <= '0;
      az_q        <= '0;
      dt_q        <= '0;
      ang_q       <= '{default: '0};
      bias_q      <= '{default: '0};
      p00_q       <= '{default: '0};
      p01_q       <= '{default: '0};
      p10_q       <= '{default: '0};
      p11_q       <= '{default: '0};
      meas_q      <= '{default: '0};
      yaw_q       <= '0;
      tmp_q       <= '0;
      k0_q        <= '0;
      k1_q        <= '0;
      a00_q       <= '0;
      a01_q       <= '0;
      dp11_q      <= '0;
      sq_q        <= '0;
      horiz_q     <= '0;
      s_q         <= '0;
      fil_q       <= 1'b0;
      go_q        <= 1'b0;
      asel_q      <= 1'b0;
      dsel_q      <= 1'b0;
      out_valid_q <= 1'b0;
      roll_q      <= '0;
      pitch_q     <= '0;
      yawo_q      <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_ANGLE_NOISE: apn_q <= cfg_data_i;
          CFG_BIAS_NOISE:  bpn_q <= cfg_data_i;
          CFG_MEAS_NOISE:  mn_q  <= cfg_data_i;
          default: ;
        endcase
      end

      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      go_q <= 1'b0;

      case (st_q)
        S_IDLE: begin
          if (in_valid_i) begin
            gx_q <= rate_x_i;
            gy_q <= rate_y_i;
            gz_q <= rate_z_i;
            ax_q <= accel_x_i;
            ay_q <= accel_y_i;
            az_q <= accel_z_i;
            dt_q <= time_step_i;
            op_q <= OP_SQY;
            st_q <= S_MUL;
          end
        end
        S_MUL: st_q <= S_WB;
        S_WB: begin
          st_q <= S_MUL;
          case (op_q)
            OP_SQY: begin
              sq_q <= prod[63:0];
              op_q <= OP_SQZ;
            end
            OP_SQZ: begin
              sq_q <= sq_q + prod[63:0];
              go_q <= 1'b1;
              st_q <= S_SQRT;
            end
            OP_ANG: begin
              ang_q[fil_q] <= sat32(40'(ang_c) + 40'(shr));
              op_q         <= OP_DP11;
            end
            OP_DP11: begin
              dp11_q <= shr[34:0];
              st_q   <= S_T;
            end
            OP_P0: begin
              p00_q[fil_q] <= sat32(40'(p00_c) + 40'(shr));
              p01_q[fil_q] <= sat32(40'(p01_c) - 40'(dp11_q));
              p10_q[fil_q] <= sat32(40'(p10_c) - 40'(dp11_q));
              op_q         <= OP_P3;
            end
            OP_P3: begin
              p11_q[fil_q] <= sat32(40'(p11_c) + 40'(shr));
              st_q         <= S_S;
            end
            OP_KA: begin
              ang_q[fil_q] <= sat32(40'(ang_c) + 40'(shr));
              op_q         <= OP_KB;
            end
            OP_KB: begin
              bias_q[fil_q] <= sat32(40'(bias_c) + 40'(shr));
              op_q          <= OP_C0;
            end
            OP_C0: begin
              p00_q[fil_q] <= sat32(40'(p00_c) - 40'(shr));
              op_q         <= OP_C1;
            end
            OP_C1: begin
              p01_q[fil_q] <= sat32(40'(p01_c) - 40'(shr));
              op_q         <= OP_C2;
            end
            OP_C2: begin
              p10_q[fil_q] <= sat32(40'(p10_c) - 40'(shr));
              op_q         <= OP_C3;
            end
            OP_C3: begin
              p11_q[fil_q] <= sat32(40'(p11_c) - 40'(shr));
              if (!fil_q) begin
                fil_q <= 1'b1;
                st_q  <= S_RATE;
              end else begin
                op_q <= OP_YAW;
              end
            end
            OP_YAW: begin
              yaw_q <= sat32(40'(yaw_q) + 40'(shr));
              st_q  <= S_DONE;
            end
            default: st_q <= S_IDLE;
          endcase
        end
        S_SQRT: begin
          if (sqrt_done) begin
            horiz_q <= root;
            asel_q  <= 1'b0;
            go_q    <= 1'b1;
            st_q    <= S_ATAN;
          end
        end
        S_ATAN: begin
          if (atan_done) begin
            if (!asel_q) begin
              meas_q[0] <= atan_ang;
              asel_q    <= 1'b1;
              go_q      <= 1'b1;
            end else begin
              meas_q[1] <= atan_ang;
              fil_q     <= 1'b0;
              st_q      <= S_RATE;
            end
          end
        end
        S_RATE: begin
          // predict: gyro minus bias drives the angle
          tmp_q <= sat32(40'(gyro_c) - 40'(bias_c));
          op_q  <= OP_ANG;
          st_q  <= S_MUL;
        end
        S_T: begin
          tmp_q <= sat32(40'(dp11_q) - 40'(p01_c) - 40'(p10_c)
                         + 40'($signed({1'b0, apn_q})));
          op_q  <= OP_P0;
          st_q  <= S_MUL;
        end
        S_S: begin
          // innovation variance; not positive means zero gains
          if (s_c > 0) begin
            s_q    <= s_c[31:0];
            dsel_q <= 1'b0;
            go_q   <= 1'b1;
            st_q   <= S_DIV;
          end else begin
            k0_q <= '0;
            k1_q <= '0;
            st_q <= S_Y;
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (!dsel_q) begin
              k0_q   <= quo;
              dsel_q <= 1'b1;
              go_q   <= 1'b1;
            end else begin
              k1_q <= quo;
              st_q <= S_Y;
            end
          end
        end
        S_Y: begin
          tmp_q <= sat32(40'(meas_q[fil_q]) - 40'(ang_c));
          a00_q <= p00_c;
          a01_q <= p01_c;
          op_q  <= OP_KA;
          st_q  <= S_MUL;
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            roll_q      <= ang_q[0];
            pitch_q     <= ang_q[1];
            yawo_q      <= yaw_q;
            out_valid_q <= 1'b1;
            st_q        <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (st_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign roll_deg_o  = roll_q;
  assign pitch_deg_o = pitch_q;
  assign yaw_deg_o   = yawo_q;

endmodule

[design/kimu_mul.sv]
// Shared 33x33 signed multiplier with a registered product.
// Depends on nothing.
module kimu_mul (
  input  logic               clk_i,
  input  logic signed [32:0] a_i,
  input  logic signed [32:0] b_i,
  output logic signed [65:0] prod_o
);

  logic signed [65:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

[design/kimu_isqrt.sv]
// Floor integer square root of a 64-bit value, two radicand bits per cycle.
// Does not import kimu_pkg; no package items used.
module kimu_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] rad_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic [63:0] v_q, r_q, bit_q, trial;
  logic        busy_q, done_q, ge;

  assign trial = r_q + bit_q;
  assign ge    = (v_q >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      v_q    <= '0;
      r_q    <= '0;
      bit_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      v_q    <= rad_i;
      r_q    <= '0;
      bit_q  <= 64'h4000_0000_0000_0000;
    end else if (busy_q) begin
      if (bit_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        if (ge) begin
          v_q <= v_q - trial;
          r_q <= (r_q >> 1) + bit_q;
        end else begin
          r_q <= r_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign root_o = r_q[31:0];

endmodule

[design/kimu_cordic.sv]
// Vectoring CORDIC for atan2 in Q16.16 degrees, one micro-rotation per cycle.
// Depends on kimu_pkg (angle constants, arctangent table).
module kimu_cordic import kimu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [32:0] y_i,
  input  logic signed [32:0] x_i,
  output logic               done_o,
  output logic signed [31:0] angle_o
);

  typedef enum logic [1:0] {C_IDLE, C_NORM, C_ITER, C_FIN} cstate_e;

  localparam logic signed [43:0] NormCoarse = 44'sd4294967296;
  localparam logic signed [43:0] NormFloor  = 44'sd1099511627776;

  cstate_e            st_q;
  logic signed [43:0] cx_q, cy_q, mx, dx, dy;
  logic signed [24:0] z_q, tab;
  logic signed [31:0] zc, a, ang_q;
  logic        [4:0]  i_q;
  logic        [32:0] ux, uy;
  logic               xneg_q, yneg_q, done_q;

  assign ux  = x_i[32] ? 33'(-x_i) : 33'(x_i);
  assign uy  = y_i[32] ? 33'(-y_i) : 33'(y_i);
  assign mx  = (cx_q > cy_q) ? cx_q : cy_q;
  assign dx  = cy_q >>> i_q;
  assign dy  = cx_q >>> i_q;
  assign tab = $signed({3'b000, atan_tab(i_q)});

  always_comb begin
    if (z_q < 0) begin
      zc = '0;
    end else if (32'(z_q) > Deg90) begin
      zc = Deg90;
    end else begin
      zc = 32'(z_q);
    end
    a = xneg_q ? (Deg180 - zc) : zc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= C_IDLE;
      done_q <= 1'b0;
      cx_q   <= '0;
      cy_q   <= '0;
      z_q    <= '0;
      i_q    <= '0;
      xneg_q <= 1'b0;
      yneg_q <= 1'b0;
      ang_q  <= '0;
    end else begin
      done_q <= 1'b0;
      case (st_q)
        C_IDLE: begin
          if (start_i) begin
            xneg_q <= x_i[32];
            yneg_q <= y_i[32];
            cx_q   <= 44'(ux);
            cy_q   <= 44'(uy);
            z_q    <= '0;
            i_q    <= '0;
            if (uy == '0) begin
              st_q <= C_FIN;
            end else if (ux == '0) begin
              z_q  <= 25'(Deg90);
              st_q <= C_FIN;
            end else begin
              st_q <= C_NORM;
            end
          end
        end
        C_NORM: begin
          if (mx < NormCoarse) begin
            cx_q <= cx_q <<< 8;
            cy_q <= cy_q <<< 8;
          end else if (mx < NormFloor) begin
            cx_q <= cx_q <<< 1;
            cy_q <= cy_q <<< 1;
          end else begin
            st_q <= C_ITER;
          end
        end
        C_ITER: begin
          if (cy_q > 0) begin
            cx_q <= cx_q + dx;
            cy_q <= cy_q - dy;
            z_q  <= z_q + tab;
          end else begin
            cx_q <= cx_q - dx;
            cy_q <= cy_q + dy;
            z_q  <= z_q - tab;
          end
          if (i_q == 5'(AtanSteps - 1)) begin
            st_q <= C_FIN;
          end else begin
            i_q <= i_q + 5'd1;
          end
        end
        C_FIN: begin
          ang_q  <= yneg_q ? -a : a;
          done_q <= 1'b1;
          st_q   <= C_IDLE;
        end
        default: st_q <= C_IDLE;
      endcase
    end
  end

  assign done_o  = done_q;
  assign angle_o = ang_q;

endmodule

[design/kimu_div.sv]
// Gain divider: (num * 2^30) / den, truncated toward zero, saturated to 32 bits.
// Restoring division, one quotient bit per cycle. Depends on kimu_pkg.
module kimu_div import kimu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] num_i,
  input  logic        [31:0] den_i,
  output logic               done_o,
  output logic signed [31:0] quo_o
);

  logic [31:0] mag, den_q;
  logic [32:0] rem_q, nlo_q, q_q, tr;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q, ovf_q, neg_q, ge;

  assign mag = num_i[31] ? 32'(-num_i) : 32'(num_i);
  assign tr  = {rem_q[31:0], nlo_q[32]};
  assign ge  = (tr >= {1'b0, den_q});

  always_comb begin
    if (!neg_q) begin
      quo_o = (ovf_q || q_q[32] || q_q[31]) ? 32'sh7fffffff : $signed(q_q[31:0]);
    end else if (ovf_q || q_q[32] || (q_q[31] && (q_q[30:0] != '0))) begin
      quo_o = 32'sh80000000;
    end else begin
      quo_o = -$signed(q_q[31:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      ovf_q  <= 1'b0;
      neg_q  <= 1'b0;
      den_q  <= '0;
      rem_q  <= '0;
      nlo_q  <= '0;
      q_q    <= '0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        neg_q  <= num_i[31];
        den_q  <= den_i;
        ovf_q  <= (32'(mag[31:3]) >= den_i);
        rem_q  <= 33'(mag[31:3]);
        nlo_q  <= {mag[2:0], 30'd0};
        q_q    <= '0;
        cnt_q  <= '0;
      end else if (busy_q) begin
        rem_q <= ge ? (tr - {1'b0, den_q}) : tr;
        q_q   <= {q_q[31:0], ge};
        nlo_q <= nlo_q << 1;
        if (cnt_q == 6'(DivSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 6'd1;
        end
      end
    end
  end

  assign done_o = done_q;

endmodule

[design/kimu_checker.sv]
// Port-level checks for the IMU attitude block, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module kimu_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] roll_deg_o,
  input logic signed [31:0] pitch_deg_o,
  input logic signed [31:0] yaw_deg_o
);

  // held result beat keeps valid and data
  `KIMU_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(roll_deg_o) && $stable(pitch_deg_o) && $stable(yaw_deg_o), "stalled result beat changed")

  // accepted sample makes the block busy
  `KIMU_ASSERT_NXT(a_busy_after_in, in_valid_i && !in_stall_o, in_stall_o, "not busy after sample beat")

  // no result right behind an accept
  `KIMU_ASSERT_NXT(a_no_early_out, in_valid_i && !in_stall_o, !$rose(out_valid_o), "result too early")

  // a new result coincides with the return to idle
  `KIMU_ASSERT_IMP(a_idle_on_out, $rose(out_valid_o), !in_stall_o, "busy when result appears")

endmodule

bind kalman_imu_roll_pitch_yaw kimu_checker u_kimu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .roll_deg_o  (roll_deg_o),
  .pitch_deg_o (pitch_deg_o),
  .yaw_deg_o   (yaw_deg_o)
);
